// File: sv/shsi_pkg.sv
// shared types, constants and the arctangent table of the heading/speed integrator
`timescale 1ns / 1ps
package shsi_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int ATAN_TABLE_LEN        = 24;

    localparam int TIME_STEP_W = 16;
    localparam int SPEED_W     = 32;
    localparam int HEADING_W   = 20;
    localparam int POS_W       = 40;
    localparam int ACCEL_W     = 31;
    localparam int TURN_W      = 19;
    localparam int TRIG_W      = 16;
    localparam int CFG_IDX_W   = 2;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 200;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_RATE  = 2'd1;

    // angles in Q4.16 radians
    localparam logic signed [20:0] TWO_PI_Q16  = 21'sd411775;
    localparam logic signed [20:0] PI_Q16      = 21'sd205887;
    localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;
    localparam logic signed [17:0] CORDIC_GAIN_Q15 = 18'sd19899;

    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0000000000001,
        ST_STEP    = 13'b0000000000010,
        ST_SLEW_UP = 13'b0000000000100,
        ST_SLEW_DN = 13'b0000000001000,
        ST_FOLD    = 13'b0000000010000,
        ST_ROT     = 13'b0000000100000,
        ST_TRIG    = 13'b0000001000000,
        ST_MUL_C   = 13'b0000010000000,
        ST_MUL_S   = 13'b0000100000000,
        ST_MUL_DX  = 13'b0001000000000,
        ST_MUL_DZ  = 13'b0010000000000,
        ST_POS_Z   = 13'b0100000000000,
        ST_DONE    = 13'b1000000000000
    } shsi_state_t;

    typedef struct packed {
        logic capture;
        logic step;
        logic slew_up;
        logic slew_dn;
        logic fold;
        logic rot;
        logic trig;
        logic mul_c;
        logic mul_s;
        logic mul_dx;
        logic mul_dz;
        logic pos_z;
        logic load_out;
    } shsi_cmd_t;

    typedef struct packed {
        logic rot_last;
    } shsi_status_t;

    function automatic logic [15:0] atan_entry(input logic [4:0] idx);
        logic [15:0] a;
        case (idx)
            5'd0:    a = 16'd51472;
            5'd1:    a = 16'd30386;
            5'd2:    a = 16'd16055;
            5'd3:    a = 16'd8150;
            5'd4:    a = 16'd4091;
            5'd5:    a = 16'd2047;
            5'd6:    a = 16'd1024;
            5'd7:    a = 16'd512;
            5'd8:    a = 16'd256;
            5'd9:    a = 16'd128;
            5'd10:   a = 16'd64;
            5'd11:   a = 16'd32;
            5'd12:   a = 16'd16;
            5'd13:   a = 16'd8;
            5'd14:   a = 16'd4;
            5'd15:   a = 16'd2;
            5'd16:   a = 16'd1;
            default: a = 16'd0;
        endcase
        return a;
    endfunction

endpackage

// File: sv/shsi_ctrl.sv
// sequencing state machine of the heading/speed integrator
`timescale 1ns / 1ps
module shsi_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  shsi_pkg::shsi_status_t status,
    output shsi_pkg::shsi_cmd_t  cmd
);
    import shsi_pkg::*;

    shsi_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_STEP;
                end
            end
            ST_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = ST_SLEW_UP;
            end
            ST_SLEW_UP:
            begin
                cmd.slew_up = 1'b1;
                state_next  = ST_SLEW_DN;
            end
            ST_SLEW_DN:
            begin
                cmd.slew_dn = 1'b1;
                state_next  = ST_FOLD;
            end
            ST_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = ST_ROT;
            end
            ST_ROT:
            begin
                cmd.rot = 1'b1;
                if (status.rot_last)
                begin
                    state_next = ST_TRIG;
                end
            end
            ST_TRIG:
            begin
                cmd.trig   = 1'b1;
                state_next = ST_MUL_C;
            end
            ST_MUL_C:
            begin
                cmd.mul_c  = 1'b1;
                state_next = ST_MUL_S;
            end
            ST_MUL_S:
            begin
                cmd.mul_s  = 1'b1;
                state_next = ST_MUL_DX;
            end
            ST_MUL_DX:
            begin
                cmd.mul_dx = 1'b1;
                state_next = ST_MUL_DZ;
            end
            ST_MUL_DZ:
            begin
                cmd.mul_dz = 1'b1;
                state_next = ST_POS_Z;
            end
            ST_POS_Z:
            begin
                cmd.pos_z  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // wait until the output register can take the item
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: sv/shsi_dp.sv
// datapath: slewing, cordic rotation, shared multiplier and output register
`timescale 1ns / 1ps
module shsi_dp
#(
    parameter int CORDIC_ITERATIONS = shsi_pkg::CORDIC_ITERATIONS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [shsi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [shsi_pkg::ACCEL_W-1:0]      cfg_data,
    input  logic [shsi_pkg::IN_DATA_W-1:0]    s_tdata,
    input  shsi_pkg::shsi_cmd_t               cmd,
    output shsi_pkg::shsi_status_t            status,
    output logic [shsi_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import shsi_pkg::*;

    localparam int ITER_RUN = (CORDIC_ITERATIONS < ATAN_TABLE_LEN) ?
                              CORDIC_ITERATIONS : ATAN_TABLE_LEN;
    localparam int IW = $clog2(ITER_RUN);

    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        logic signed [31:0] r;
        if (v > 49'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -49'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat32s(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -34'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [19:0] sat20(input logic signed [21:0] v);
        logic signed [19:0] r;
        if (v > 22'sd524287)
            r = 20'sh7ffff;
        else if (v < -22'sd524288)
            r = 20'sh80000;
        else
            r = v[19:0];
        return r;
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
        logic signed [39:0] r;
        if (v > 42'sd549755813887)
            r = 40'sh7fffffffff;
        else if (v < -42'sd549755813888)
            r = 40'sh8000000000;
        else
            r = v[39:0];
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767)
            r = 16'sh7fff;
        else if (v < -18'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    // configuration and persistent state
    logic [ACCEL_W-1:0]          accel_reg;
    logic [TURN_W-1:0]           turn_reg;
    logic signed [SPEED_W-1:0]   speed_reg, speed_next;
    logic signed [HEADING_W-1:0] heading_reg, heading_next;
    logic signed [POS_W-1:0]     pos_x_reg, pos_x_next;
    logic signed [POS_W-1:0]     pos_z_reg, pos_z_next;

    // per-item working registers
    logic [TIME_STEP_W-1:0]      dt_reg;
    logic signed [SPEED_W-1:0]   tspd_reg;
    logic signed [HEADING_W-1:0] thdg_reg;
    logic [ACCEL_W-1:0]          sstep_reg;
    logic [TURN_W-1:0]           hstep_reg;
    logic signed [17:0]          x_reg, x_next;
    logic signed [17:0]          y_reg, y_next;
    logic signed [20:0]          z_reg, z_next;
    logic                        neg_reg, neg_next;
    logic [IW-1:0]               iter_reg, iter_next;
    logic signed [TRIG_W-1:0]    cos_reg, sin_reg;
    logic signed [48:0]          prod_reg, prod_next;
    logic signed [SPEED_W-1:0]   vx_reg, vx_next;
    logic signed [SPEED_W-1:0]   vz_reg, vz_next;
    logic [OUT_DATA_W-1:0]       out_reg;

    logic [ACCEL_W+TIME_STEP_W-1:0] sprod;
    logic [TURN_W+TIME_STEP_W-1:0]  hprod;
    logic signed [20:0]          ang_a, ang_b, ang_c;
    logic signed [17:0]          dx, dy, xn, yn;
    logic [15:0]                 atan_val;
    logic signed [16:0]          dt_s;

    assign sprod    = (ACCEL_W+TIME_STEP_W)'(accel_reg) * (ACCEL_W+TIME_STEP_W)'(dt_reg);
    assign hprod    = (TURN_W+TIME_STEP_W)'(turn_reg) * (TURN_W+TIME_STEP_W)'(dt_reg);
    assign dt_s     = signed'({1'b0, dt_reg});
    assign atan_val = atan_entry(5'(iter_reg));
    assign dx       = y_reg >>> iter_reg;
    assign dy       = x_reg >>> iter_reg;
    assign status.rot_last = (iter_reg == IW'(ITER_RUN - 1));

    // range reduction of the trig input only
    always_comb
    begin
        ang_a    = 21'(heading_reg);
        if (ang_a > PI_Q16)
            ang_a = ang_a - TWO_PI_Q16;
        ang_b    = ang_a;
        if (ang_b < -PI_Q16)
            ang_b = ang_b + TWO_PI_Q16;
        ang_c    = ang_b;
        neg_next = neg_reg;
        if (cmd.fold)
            neg_next = 1'b0;
        if (ang_b > HALF_PI_Q16)
        begin
            ang_c = ang_b - PI_Q16;
            if (cmd.fold)
                neg_next = 1'b1;
        end
        else if (ang_b < -HALF_PI_Q16)
        begin
            ang_c = ang_b + PI_Q16;
            if (cmd.fold)
                neg_next = 1'b1;
        end
    end

    always_comb
    begin
        speed_next   = speed_reg;
        heading_next = heading_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        iter_next    = iter_reg;
        prod_next    = prod_reg;
        vx_next      = vx_reg;
        vz_next      = vz_reg;
        pos_x_next   = pos_x_reg;
        pos_z_next   = pos_z_reg;
        xn           = neg_reg ? -x_reg : x_reg;
        yn           = neg_reg ? -y_reg : y_reg;

        if (cmd.slew_up)
        begin
            if (speed_reg < tspd_reg)
                speed_next = sat32s(34'(speed_reg) + 34'(signed'({1'b0, sstep_reg})));
            if (heading_reg < thdg_reg)
                heading_next = sat20(22'(heading_reg) + 22'(signed'({1'b0, hstep_reg})));
        end
        if (cmd.slew_dn)
        begin
            if (speed_reg > tspd_reg)
                speed_next = sat32s(34'(speed_reg) - 34'(signed'({1'b0, sstep_reg})));
            if (heading_reg > thdg_reg)
                heading_next = sat20(22'(heading_reg) - 22'(signed'({1'b0, hstep_reg})));
        end
        if (cmd.fold)
        begin
            x_next    = CORDIC_GAIN_Q15;
            y_next    = '0;
            z_next    = ang_c;
            iter_next = '0;
        end
        if (cmd.rot)
        begin
            if (z_reg >= 0)
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - signed'({5'b0, atan_val});
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + signed'({5'b0, atan_val});
            end
            iter_next = iter_reg + 1'b1;
        end
        // one multiplier shared by the four products, each saturated or accumulated in the cycle after it is formed
        if (cmd.mul_c)
            prod_next = 49'(cos_reg) * 49'(speed_reg);
        if (cmd.mul_s)
        begin
            vx_next   = sat32(prod_reg >>> 15);
            prod_next = 49'(sin_reg) * 49'(speed_reg);
        end
        if (cmd.mul_dx)
        begin
            vz_next   = sat32(prod_reg >>> 15);
            prod_next = 49'(vx_reg) * 49'(dt_s);
        end
        if (cmd.mul_dz)
        begin
            pos_x_next = sat40(42'(pos_x_reg) + 42'(prod_reg >>> 16));
            prod_next  = 49'(vz_reg) * 49'(dt_s);
        end
        if (cmd.pos_z)
            pos_z_next = sat40(42'(pos_z_reg) + 42'(prod_reg >>> 16));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg   <= '0;
            turn_reg    <= '0;
            speed_reg   <= '0;
            heading_reg <= '0;
            pos_x_reg   <= '0;
            pos_z_reg   <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_ACCEL_RATE))
                accel_reg <= cfg_data;
            if (cfg_we && (cfg_index == REG_TURN_RATE))
                turn_reg <= cfg_data[TURN_W-1:0];
            speed_reg   <= speed_next;
            heading_reg <= heading_next;
            pos_x_reg   <= pos_x_next;
            pos_z_reg   <= pos_z_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            dt_reg   <= s_tdata[15:0];
            tspd_reg <= s_tdata[47:16];
            thdg_reg <= s_tdata[67:48];
        end
        if (cmd.step)
        begin
            sstep_reg <= sprod[ACCEL_W+TIME_STEP_W-1:TIME_STEP_W];
            hstep_reg <= hprod[TURN_W+TIME_STEP_W-1:TIME_STEP_W];
        end
        if (cmd.trig)
        begin
            cos_reg <= sat16(xn);
            sin_reg <= sat16(yn);
        end
        if (cmd.load_out)
            out_reg <= {4'b0, heading_reg, speed_reg, vz_reg, vx_reg, pos_z_reg, pos_x_reg};
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        neg_reg  <= neg_next;
        iter_reg <= iter_next;
        prod_reg <= prod_next;
        vx_reg   <= vx_next;
        vz_reg   <= vz_next;
    end

    assign m_tdata = out_reg;

endmodule

// File: sv/slewed_heading_speed_integrator_core.sv
// top level: slewed heading/speed dead-reckoning integrator
// an accepted item passes the states step, slew up, slew down, fold, cordic rotation, trig,
// four multiply states, pos z and done before m_tvalid; a new item is accepted only in idle,
// and the single cordic rotation stage runs one iteration per cycle
// a finished item waits in the output register while the next item is accepted
// reset (rst_n, async low) clears speed, heading, position and both rate registers
`timescale 1ns / 1ps
module slewed_heading_speed_integrator_core
#(
    parameter int CORDIC_ITERATIONS = shsi_pkg::CORDIC_ITERATIONS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [shsi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [shsi_pkg::ACCEL_W-1:0]     cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // time_step[15:0], target_speed[47:16], target_heading[67:48], zero fill
    input  logic [shsi_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // position_x[39:0], position_z[79:40], velocity_x[111:80], velocity_z[143:112],
    // current_speed[175:144], current_heading[195:176], zero fill
    output logic [shsi_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import shsi_pkg::*;

    shsi_cmd_t    cmd;
    shsi_status_t status;

    shsi_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    shsi_dp #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata)
    );

endmodule
